/* rtl/hotc_pkg.sv */
// Shared types and constants for the heater offset trim controller.
package hotc_pkg;

	localparam int LIMIT_FACTOR = 50;

	localparam int FLOW_W   = 11;
	localparam int TEMP_W   = 12;
	localparam int OFFSET_W = 18;
	localparam int CALC_W   = OFFSET_W + 1;
	localparam int CMP_W    = TEMP_W + 2;
	localparam int RISE_W   = 5;
	localparam int FALL_W   = 2;

	localparam logic [1:0] DIR_STEADY = 2'd0;
	localparam logic [1:0] DIR_RAISE  = 2'd1;
	localparam logic [1:0] DIR_LOWER  = 2'd2;

	localparam logic signed [CMP_W-1:0] RAISE_BAND     = 14'sd5;
	localparam logic signed [CMP_W-1:0] NEAR_BAND      = 14'sd30;
	localparam logic signed [CMP_W-1:0] LOWER_BAND     = 14'sd10;
	localparam logic signed [CMP_W-1:0] FAST_OUT_LIMIT = 14'sd950;
	localparam logic signed [CMP_W-1:0] ELEM_FAST_TEMP = 14'sd990;
	localparam logic signed [CMP_W-1:0] OUT_HOT_TEMP   = 14'sd998;
	localparam logic signed [CMP_W-1:0] ELEM_HOT_TEMP  = 14'sd1010;

	localparam logic [RISE_W-1:0] RISE_DWELL_FAST = 5'd1;
	localparam logic [RISE_W-1:0] RISE_DWELL_HOT  = 5'd3;
	localparam logic [RISE_W-1:0] RISE_DWELL_NEG  = 5'd10;
	localparam logic [RISE_W-1:0] RISE_DWELL_POS  = 5'd30;
	localparam logic [RISE_W-1:0] RISE_DWELL_FAR  = 5'd10;
	localparam logic [FALL_W-1:0] FALL_DWELL_FAST = 2'd1;
	localparam logic [FALL_W-1:0] FALL_DWELL_SLOW = 2'd3;

	typedef struct packed {
		logic [FLOW_W-1:0]        flow_power;
		logic signed [TEMP_W-1:0] target_temp;
		logic signed [TEMP_W-1:0] outlet_temp;
		logic signed [TEMP_W-1:0] element_temp;
		logic                     preset_fast;
	} item_t;

	typedef struct packed {
		logic signed [OFFSET_W-1:0] offset;
		logic [1:0]                 dir;
		logic [RISE_W-1:0]          rise;
		logic [FALL_W-1:0]          fall;
	} trim_state_t;

endpackage

/* rtl/hotc_trim.sv */
// Next-state logic for one control tick: dwell counting, offset step and clamps.
module hotc_trim (
	input  hotc_pkg::item_t       item,
	input  hotc_pkg::trim_state_t cur,
	output hotc_pkg::trim_state_t nxt
);
	import hotc_pkg::*;

	logic [CALC_W-1:0]          lim_u;
	logic signed [CALC_W-1:0]   lim_hi;
	logic signed [CALC_W-1:0]   lim_lo;
	logic signed [CALC_W-1:0]   step;
	logic signed [CALC_W-1:0]   off_cur;
	logic signed [CALC_W-1:0]   off_up;
	logic signed [CALC_W-1:0]   off_dn;
	logic signed [CALC_W-1:0]   off_new;
	logic signed [CMP_W-1:0]    tgt;
	logic signed [CMP_W-1:0]    outl;
	logic signed [CMP_W-1:0]    elem;
	logic                       raise;
	logic                       lower;
	logic [RISE_W-1:0]          rise_inc;
	logic [FALL_W-1:0]          fall_inc;
	logic [RISE_W-1:0]          rise_dwell;
	logic [FALL_W-1:0]          fall_dwell;
	logic [1:0]                 dir_new;

	assign lim_u   = CALC_W'(item.flow_power) * CALC_W'(LIMIT_FACTOR);
	assign lim_hi  = $signed(lim_u);
	assign lim_lo  = -lim_hi;
	assign step    = $signed(CALC_W'(item.flow_power[FLOW_W-1:1]));
	assign off_cur = CALC_W'(cur.offset);
	assign off_up  = off_cur + step;
	assign off_dn  = off_cur - step;

	assign tgt  = CMP_W'(item.target_temp);
	assign outl = CMP_W'(item.outlet_temp);
	assign elem = CMP_W'(item.element_temp);

	assign raise = tgt > (outl - RAISE_BAND);
	assign lower = tgt < (outl + LOWER_BAND);

	assign rise_inc = cur.rise + RISE_W'(1);
	assign fall_inc = cur.fall + FALL_W'(1);

	always_comb begin
		if (item.preset_fast) begin
			rise_dwell = (outl < FAST_OUT_LIMIT) ? RISE_DWELL_FAST : RISE_DWELL_HOT;
		end else if (tgt >= (outl - NEAR_BAND)) begin
			rise_dwell = cur.offset[OFFSET_W-1] ? RISE_DWELL_NEG : RISE_DWELL_POS;
		end else begin
			rise_dwell = RISE_DWELL_FAR;
		end
		fall_dwell = (elem > ELEM_FAST_TEMP) ? FALL_DWELL_FAST : FALL_DWELL_SLOW;
	end

	always_comb begin
		off_new  = off_cur;
		nxt.rise = '0;
		nxt.fall = '0;
		if (raise) begin
			dir_new = DIR_RAISE;
			if (rise_inc >= rise_dwell) begin
				off_new = (off_up >= lim_hi) ? lim_hi : off_up;
			end else begin
				nxt.rise = rise_inc;
			end
		end else if (lower) begin
			dir_new = DIR_LOWER;
			if (fall_inc >= fall_dwell) begin
				off_new = (off_dn <= lim_lo) ? lim_lo : off_dn;
			end else begin
				nxt.fall = fall_inc;
			end
		end else begin
			dir_new = DIR_STEADY;
		end
		if (dir_new != DIR_STEADY && dir_new != cur.dir) begin
			off_new = '0;
		end
		if (outl >= OUT_HOT_TEMP || elem >= ELEM_HOT_TEMP) begin
			off_new = lim_lo;
		end
		nxt.offset = off_new[OFFSET_W-1:0];
		nxt.dir    = dir_new;
	end

endmodule

/* rtl/heater_offset_trim_controller.sv */
// Top level of the heater offset trim controller: input, state and result registers.
// One item per clock cycle sustained while the result register is not stalled. An accepted item is
// captured in the input register; the trim logic then updates the offset, direction and dwell
// counters and loads the result register. The tick state lives in single registers updated in
// the same cycle the result is loaded, which lets the next item follow directly. While the result
// register is stalled, one more item is held in the input register before stall is raised on the
// input side.
module heater_offset_trim_controller (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [hotc_pkg::FLOW_W-1:0]             flow_power,
	input  logic signed [hotc_pkg::TEMP_W-1:0]      target_temp,
	input  logic signed [hotc_pkg::TEMP_W-1:0]      outlet_temp,
	input  logic signed [hotc_pkg::TEMP_W-1:0]      element_temp,
	input  logic                                    preset_fast,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [hotc_pkg::OFFSET_W-1:0]    power_offset,
	output logic [1:0]                              direction
);
	import hotc_pkg::*;

	item_t       item_s1;
	logic        valid_s1;
	trim_state_t state_q;
	trim_state_t state_nxt;
	logic        out_valid_q;
	logic        out_free;
	logic        advance;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.flow_power   <= flow_power;
			item_s1.target_temp  <= target_temp;
			item_s1.outlet_temp  <= outlet_temp;
			item_s1.element_temp <= element_temp;
			item_s1.preset_fast  <= preset_fast;
		end
	end

	hotc_trim u_trim (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			power_offset <= state_nxt.offset;
			direction    <= state_nxt.dir;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* tb/heater_offset_trim_controller_tb.sv */
// Testbench for the heater offset trim controller: directed and random ticks checked against a predictor.
module heater_offset_trim_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hotc_pkg::*;

	typedef struct packed {
		logic signed [OFFSET_W-1:0] power_offset;
		logic [1:0]                 direction;
	} trim_result_t;

	class trim_scoreboard;
		int           trim_offset;
		logic [1:0]   trim_dir;
		logic [RISE_W-1:0] rise_count;
		logic [FALL_W-1:0] fall_count;
		trim_result_t expected_trims[$];
		int           errors;

		function new();
			trim_offset = 0;
			trim_dir    = DIR_STEADY;
			rise_count  = '0;
			fall_count  = '0;
			errors      = 0;
		endfunction

		function void note_tick(item_t t);
			int           fp;
			int           tgt;
			int           outl;
			int           elem;
			int           step;
			int           lim;
			int           dwell;
			int           off;
			logic [1:0]   nd;
			trim_result_t res;
			fp   = int'(t.flow_power);
			tgt  = int'($signed(t.target_temp));
			outl = int'($signed(t.outlet_temp));
			elem = int'($signed(t.element_temp));
			step = fp / 2;
			lim  = fp * LIMIT_FACTOR;
			off  = trim_offset;
			if (tgt > outl - RAISE_BAND) begin
				nd = DIR_RAISE;
				fall_count = '0;
				rise_count = rise_count + RISE_W'(1);
				if (t.preset_fast)
					dwell = int'((outl < FAST_OUT_LIMIT) ? RISE_DWELL_FAST : RISE_DWELL_HOT);
				else if (tgt >= outl - NEAR_BAND)
					dwell = int'((off < 0) ? RISE_DWELL_NEG : RISE_DWELL_POS);
				else
					dwell = int'(RISE_DWELL_FAR);
				if (int'(rise_count) >= dwell) begin
					rise_count = '0;
					off = off + step;
					if (off >= lim)
						off = lim;
				end
			end else if (tgt < outl + LOWER_BAND) begin
				nd = DIR_LOWER;
				rise_count = '0;
				fall_count = fall_count + FALL_W'(1);
				dwell = int'((elem > ELEM_FAST_TEMP) ? FALL_DWELL_FAST : FALL_DWELL_SLOW);
				if (int'(fall_count) >= dwell) begin
					fall_count = '0;
					off = off - step;
					if (off <= -lim)
						off = -lim;
				end
			end else begin
				nd = DIR_STEADY;
				rise_count = '0;
				fall_count = '0;
			end
			if (nd != DIR_STEADY && nd != trim_dir)
				off = 0;
			if (outl >= OUT_HOT_TEMP || elem >= ELEM_HOT_TEMP)
				off = -lim;
			trim_offset = off;
			trim_dir    = nd;
			res.power_offset = OFFSET_W'(off);
			res.direction    = nd;
			expected_trims.push_back(res);
		endfunction

		function void check_result(logic signed [OFFSET_W-1:0] off, logic [1:0] dir);
			trim_result_t exp_res;
			if (expected_trims.size() == 0) begin
				$error("result with no item pending: power_offset %0d direction %0d", off, dir);
				errors++;
				return;
			end
			exp_res = expected_trims.pop_front();
			if (off !== exp_res.power_offset) begin
				$error("power_offset: expected %0d, got %0d", exp_res.power_offset, off);
				errors++;
			end
			if (dir !== exp_res.direction) begin
				$error("direction: expected %0d, got %0d", exp_res.direction, dir);
				errors++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n       = 1'b0;
	logic                       in_valid     = 1'b0;
	logic                       in_stall;
	logic [FLOW_W-1:0]          flow_power   = '0;
	logic signed [TEMP_W-1:0]   target_temp  = '0;
	logic signed [TEMP_W-1:0]   outlet_temp  = '0;
	logic signed [TEMP_W-1:0]   element_temp = '0;
	logic                       preset_fast  = 1'b0;
	logic                       out_valid;
	logic                       out_stall    = 1'b0;
	logic signed [OFFSET_W-1:0] power_offset;
	logic [1:0]                 direction;

	logic   hold_off  = 1'b0;
	int     stall_pct = 0;
	int     idle_pct  = 0;
	int     sent_count = 0;
	item_t  tick_plan[$];
	trim_scoreboard sb = new();

	heater_offset_trim_controller dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.flow_power   (flow_power),
		.target_temp  (target_temp),
		.outlet_temp  (outlet_temp),
		.element_temp (element_temp),
		.preset_fast  (preset_fast),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.power_offset (power_offset),
		.direction    (direction)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(power_offset, direction);
		out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		wait (sent_count >= 60);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (120) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic void add_tick(int fp, int tgt, int outl, int elem, bit fast);
		item_t t;
		t.flow_power   = fp[FLOW_W-1:0];
		t.target_temp  = tgt[TEMP_W-1:0];
		t.outlet_temp  = outl[TEMP_W-1:0];
		t.element_temp = elem[TEMP_W-1:0];
		t.preset_fast  = fast;
		tick_plan.push_back(t);
	endfunction

	function automatic int pick_flow();
		case ($urandom_range(0, 3))
			0: return int'($urandom_range(0, 7));
			1: return $urandom_range(0, 1) ? 2047 : 0;
			default: return int'($urandom_range(0, 2047));
		endcase
	endfunction

	task automatic build_random(int total);
		int  kind;
		int  len;
		int  fp;
		int  outl;
		int  tgt;
		int  elem;
		bit  fast;
		bit  raising;
		bit  sustained;
		while (tick_plan.size() < total) begin
			kind = $urandom_range(0, 19);
			fp   = pick_flow();
			fast = 1'($urandom_range(0, 1));
			if (kind < 2) begin
				repeat ($urandom_range(1, 6))
					add_tick($urandom, $urandom, $urandom, $urandom,
						1'($urandom_range(0, 1)));
				continue;
			end
			sustained = (kind == 2);
			raising   = 1'($urandom_range(0, 1));
			len = sustained ? $urandom_range(100, 130) : $urandom_range(1, 40);
			repeat (len) begin
				if (!sustained && $urandom_range(0, 14) == 0)
					fp = pick_flow();
				if (!sustained && $urandom_range(0, 9) == 0)
					fast = ~fast;
				outl = int'($urandom_range(0, 1390)) - 400;
				if (sustained && raising)
					outl = int'($urandom_range(0, 1349)) - 400;
				else if (!sustained && $urandom_range(0, 19) == 0)
					outl = 998 + int'($urandom_range(0, 502));
				if (raising)
					tgt = outl - 4 + int'($urandom_range(0, 60));
				else
					tgt = outl - 5 - int'($urandom_range(0, 60));
				if (sustained)
					elem = raising ? int'($urandom_range(0, 1390)) - 400
						: 991 + int'($urandom_range(0, 18));
				else if ($urandom_range(0, 2) == 0)
					elem = 985 + int'($urandom_range(0, 24));
				else if ($urandom_range(0, 24) == 0)
					elem = 1010 + int'($urandom_range(0, 490));
				else
					elem = int'($urandom_range(0, 1390)) - 400;
				add_tick(fp, tgt, outl, elem, sustained ? 1'b1 : fast);
			end
		end
	endtask

	initial begin
		int n;
		add_tick(2047, 600, 500, 500, 1);
		add_tick(2047, 600, 500, 500, 1);
		repeat (3) add_tick(2047, 960, 955, 500, 1);
		repeat (2) add_tick(2047, 400, 500, 995, 0);
		repeat (3) add_tick(2047, 400, 500, 990, 0);
		add_tick(2047, 495, 500, 0, 0);
		add_tick(2047, 496, 500, 0, 0);
		add_tick(2047, 1500, 998, 0, 0);
		add_tick(100, 500, 480, 1009, 0);
		add_tick(0, 0, 0, 1010, 0);
		add_tick(0, -2048, 2047, -2048, 0);
		add_tick(2047, 2047, -2048, 2047, 1);
		add_tick(1, -2048, -2048, 989, 0);
		add_tick(1024, 2047, 2047, 0, 1);
		add_tick(2047, -400, 1500, -400, 0);
		add_tick(2047, 1500, -400, 1500, 1);
		build_random(tick_plan.size() + 550);
		n = tick_plan.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (tick_plan[i]) begin
			if (i < n / 4) begin
				idle_pct = 0;
				stall_pct = 0;
			end else if (i < n / 2) begin
				idle_pct = 74;
				stall_pct = 0;
			end else if (i < 3 * n / 4) begin
				idle_pct = 0;
				stall_pct = 74;
			end else begin
				idle_pct = 37;
				stall_pct = 37;
			end
			while ($urandom_range(0, 99) < idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid     <= 1'b1;
			flow_power   <= tick_plan[i].flow_power;
			target_temp  <= tick_plan[i].target_temp;
			outlet_temp  <= tick_plan[i].outlet_temp;
			element_temp <= tick_plan[i].element_temp;
			preset_fast  <= tick_plan[i].preset_fast;
			do @(posedge clk); while (in_stall);
			sb.note_tick(tick_plan[i]);
			sent_count++;
		end
		in_valid <= 1'b0;
		stall_pct = 0;

		while (sb.expected_trims.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
